// ===== hdl/irtx_pkg.sv =====
package irtx_pkg;

	localparam int unsigned SLOT_W = 4;
	localparam int unsigned BYTE_W = 8;
	localparam logic [SLOT_W-1:0] START_SLOT = 4'd0;
	localparam logic [SLOT_W-1:0] DATA_END_SLOT = 4'd9;

	typedef enum logic {
		ACT_TICK = 1'b0,
		ACT_LOAD = 1'b1
	} action_t;

	typedef struct packed {
		logic ir_level;
		logic busy_res;
		logic accepted;
	} result_t;

endpackage

// ===== hdl/irtx_if.sv =====
interface irtx_cmd_if;
	import irtx_pkg::*;
	logic valid;
	logic ready;
	logic action;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface irtx_res_if;
	logic valid;
	logic ready;
	logic ir_level;
	logic busy_res;
	logic accepted;

	modport source (output valid, output ir_level, output busy_res, output accepted, input ready);
	modport sink (input valid, input ir_level, input busy_res, input accepted, output ready);
endinterface

// ===== hdl/irtx_frame_core.sv =====
module irtx_frame_core
	import irtx_pkg::*;
#(
	parameter int unsigned TICKS_PER_SLOT = 16,
	parameter int unsigned FRAME_END_SLOT = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              action,
	input  logic [BYTE_W-1:0] data_byte,
	output result_t           result
);

	localparam int unsigned PHASE_W = $clog2(TICKS_PER_SLOT);
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(TICKS_PER_SLOT - 1);
	localparam logic [SLOT_W-1:0] END_SLOT = SLOT_W'(FRAME_END_SLOT);

	logic              idle_q, idle_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic              carrier_q, carrier_d;
	logic              bit_q, bit_d;
	logic [BYTE_W-1:0] shift_q, shift_d;
	logic [BYTE_W-1:0] pending_q, pending_d;

	always_comb begin
		idle_d    = idle_q;
		slot_d    = slot_q;
		phase_d   = phase_q;
		carrier_d = carrier_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		pending_d = pending_q;
		result    = '0;
		if (action == ACT_LOAD) begin
			if (idle_q) begin
				pending_d       = data_byte;
				slot_d          = START_SLOT;
				idle_d          = 1'b0;
				result.accepted = 1'b1;
			end
		end else begin
			result.ir_level = carrier_q & bit_q;
			carrier_d = ~carrier_q;
			if (phase_q == PHASE_LAST) begin
				phase_d = '0;
				if (!idle_q) begin
					priority if (slot_q == START_SLOT) begin
						bit_d   = 1'b1;
						shift_d = pending_q;
						slot_d  = slot_q + 1'b1;
					end else if (slot_q < DATA_END_SLOT) begin
						bit_d   = ~shift_q[0];
						shift_d = shift_q >> 1;
						slot_d  = slot_q + 1'b1;
					end else if (slot_q < END_SLOT) begin
						bit_d  = 1'b0;
						slot_d = slot_q + 1'b1;
					end else begin
						idle_d = 1'b1;
						bit_d  = 1'b0;
					end
				end
			end else begin
				phase_d = phase_q + 1'b1;
			end
		end
		result.busy_res = ~idle_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q    <= 1'b1;
			slot_q    <= '0;
			phase_q   <= '0;
			carrier_q <= 1'b0;
			bit_q     <= 1'b0;
			shift_q   <= '0;
			pending_q <= '0;
		end else if (step) begin
			idle_q    <= idle_d;
			slot_q    <= slot_d;
			phase_q   <= phase_d;
			carrier_q <= carrier_d;
			bit_q     <= bit_d;
			shift_q   <= shift_d;
			pending_q <= pending_d;
		end
	end

	// frame never runs past the last slot
	assert property (@(posedge clk) disable iff (!arst_n) slot_q <= END_SLOT)
		else $error("slot count beyond frame end");

	// an accepted load starts a frame at the start slot
	assert property (@(posedge clk) disable iff (!arst_n)
		step && result.accepted |=> !idle_q && slot_q == START_SLOT)
		else $error("accepted load did not start a frame");

	// a refused load leaves the state alone
	assert property (@(posedge clk) disable iff (!arst_n)
		step && action == ACT_LOAD && !idle_q |=> $stable(pending_q) && $stable(phase_q))
		else $error("refused load changed state");

endmodule

// ===== hdl/ir_carrier_uart_transmitter_top.sv =====
// infrared serial transmitter with a carrier
// cmd channel: action 0 is one timer tick, action 1 loads data_byte. a load is
// taken only while no frame runs; a refused load still gives a result with
// accepted low, so the sender never waits on it.
// res channel: one transfer per cmd transfer, in order: ir_level (pin level for
// that tick, carrier gated), busy_res (frame in progress after the item) and
// accepted.
// a cmd item is held in the input register, which feeds the state update; its
// result is loaded into the result register when the item advances, and the
// res transfer is made from there.
// throughput: one item per cycle while res is not stalled, set by the single
// state update per item. when res is stalled the result register holds, the
// input register fills and cmd.ready drops; no item is lost or repeated.
// reset: idle, frame counters, carrier and bit level cleared, both pipeline
// stages empty.
module ir_carrier_uart_transmitter_top
	import irtx_pkg::*;
#(
	parameter int unsigned TICKS_PER_SLOT = 16,
	parameter int unsigned FRAME_END_SLOT = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	irtx_cmd_if.sink  cmd,
	irtx_res_if.source res
);

	logic              valid_s1;
	logic              action_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              valid_s2;
	result_t           result_s2;
	result_t           result_c;
	logic              advance;

	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			action_s1 <= cmd.action;
			data_s1   <= cmd.data_byte;
		end
	end

	irtx_frame_core #(
		.TICKS_PER_SLOT(TICKS_PER_SLOT),
		.FRAME_END_SLOT(FRAME_END_SLOT)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.action   (action_s1),
		.data_byte(data_s1),
		.result   (result_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || res.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_c;
		end
	end

	assign res.valid    = valid_s2;
	assign res.ir_level = result_s2.ir_level;
	assign res.busy_res = result_s2.busy_res;
	assign res.accepted = result_s2.accepted;

	// an accepted load always leaves a frame running
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (!res.accepted || res.busy_res))
		else $error("accepted without busy");

	// a load result never drives the pin
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.ir_level && res.accepted))
		else $error("load result drove the pin");

	// with the result stage empty the input side is never blocked
	assert property (@(posedge clk) disable iff (!arst_n) !valid_s2 |-> cmd.ready)
		else $error("input blocked with empty result stage");

	// a stalled item in the input register holds
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(action_s1) && $stable(data_s1))
		else $error("stalled input item changed");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	import irtx_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TICKS = 16;
	localparam int unsigned FRAME_END = 10;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned ITEM_TARGET = 550;

	typedef struct packed {
		action_t act;
		logic [BYTE_W-1:0] dbyte;
	} tx_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	irtx_cmd_if cmd ();
	irtx_res_if res ();

	ir_carrier_uart_transmitter_top #(
		.TICKS_PER_SLOT(TICKS),
		.FRAME_END_SLOT(FRAME_END)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.res(res)
	);

	always #1 clk = ~clk;

	// transmitter state as seen by the predictor
	logic tx_idle = 1'b1;
	logic [SLOT_W-1:0] tx_slot = '0;
	int unsigned tx_phase = 0;
	logic tx_carrier = 1'b0;
	logic tx_bit = 1'b0;
	logic [BYTE_W-1:0] tx_shift = '0;
	logic [BYTE_W-1:0] tx_pend = '0;

	tx_cmd_t cmd_items[$];
	result_t expected_results[$];

	tx_cmd_t cur_cmd;
	int burst_left = 0;
	int gap_left = 0;
	int ready_pct = 100;
	int ready_hold = 0;
	int stall_cycles = 0;
	int err_cnt = 0;
	int res_cnt = 0;
	int loads_taken = 0;
	int loads_refused = 0;
	int frames_sent = 0;
	int pin_pulses = 0;
	result_t mon_exp;
	result_t pred_res;

	task automatic predict_pin(input tx_cmd_t c, output result_t r);
		logic level;
		logic took;
		level = 1'b0;
		took = 1'b0;
		if (c.act == ACT_LOAD) begin
			if (tx_idle) begin
				tx_pend = c.dbyte;
				tx_slot = START_SLOT;
				tx_idle = 1'b0;
				took = 1'b1;
				loads_taken++;
			end else begin
				loads_refused++;
			end
		end else begin
			level = tx_carrier & tx_bit;
			if (level)
				pin_pulses++;
			tx_carrier = ~tx_carrier;
			tx_phase++;
			if (tx_phase >= TICKS) begin
				tx_phase = 0;
				if (!tx_idle) begin
					if (tx_slot == START_SLOT) begin
						tx_bit = 1'b1;
						tx_shift = tx_pend;
						tx_slot = tx_slot + 1'b1;
					end else if (tx_slot < DATA_END_SLOT) begin
						tx_bit = ~tx_shift[0];
						tx_shift = tx_shift >> 1;
						tx_slot = tx_slot + 1'b1;
					end else if (tx_slot < FRAME_END) begin
						tx_bit = 1'b0;
						tx_slot = tx_slot + 1'b1;
					end else begin
						tx_idle = 1'b1;
						tx_bit = 1'b0;
						frames_sent++;
					end
				end
			end
		end
		r.ir_level = level;
		r.busy_res = ~tx_idle;
		r.accepted = took;
	endtask

	task automatic push_cmd(input action_t act, input logic [BYTE_W-1:0] b);
		tx_cmd_t c;
		c.act = act;
		c.dbyte = b;
		cmd_items.push_back(c);
	endtask

	task automatic push_ticks(input int n);
		for (int i = 0; i < n; i++)
			push_cmd(ACT_TICK, BYTE_W'($urandom));
	endtask

	// sender: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			cmd.action <= ACT_TICK;
			cmd.data_byte <= '0;
			burst_left = $urandom_range(1, 40);
			gap_left = 0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				predict_pin(cur_cmd, pred_res);
				expected_results.push_back(pred_res);
			end
			if (!cmd.valid || cmd.ready) begin
				if (gap_left > 0 || cmd_items.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					cmd.valid <= 1'b0;
				end else begin
					cur_cmd = cmd_items.pop_front();
					cmd.valid <= 1'b1;
					cmd.action <= cur_cmd.act;
					cmd.data_byte <= cur_cmd.dbyte;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// receiver: random ready, with the stall rate picked anew whenever its hold count runs out
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			ready_hold = 0;
		end else begin
			if (ready_hold == 0) begin
				case ($urandom_range(0, 3))
					0: ready_pct = 100;
					1: ready_pct = 85;
					2: ready_pct = 50;
					default: ready_pct = 15;
				endcase
				ready_hold = $urandom_range(20, 120);
			end else begin
				ready_hold--;
			end
			res.ready <= ($urandom_range(1, 100) <= ready_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			res_cnt++;
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected");
				err_cnt++;
			end else begin
				mon_exp = expected_results.pop_front();
				if (res.ir_level !== mon_exp.ir_level) begin
					$error("ir_level: expected %0b, got %0b", mon_exp.ir_level, res.ir_level);
					err_cnt++;
				end
				if (res.busy_res !== mon_exp.busy_res) begin
					$error("busy_res: expected %0b, got %0b", mon_exp.busy_res, res.busy_res);
					err_cnt++;
				end
				if (res.accepted !== mon_exp.accepted) begin
					$error("accepted: expected %0b, got %0b", mon_exp.accepted, res.accepted);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		logic [BYTE_W-1:0] fbyte;
		int frame_idx;
		int n;
		cmd.valid = 1'b0;
		cmd.action = ACT_TICK;
		cmd.data_byte = '0;
		res.ready = 1'b0;

		// directed: idle ticks, taken load, refused loads, then drain the frame
		push_ticks(5);
		push_cmd(ACT_LOAD, 8'h00);
		push_cmd(ACT_LOAD, 8'hFF);
		push_ticks(3);
		push_cmd(ACT_LOAD, 8'hA5);
		push_ticks(10);
		push_cmd(ACT_LOAD, 8'h5A);
		push_ticks(190);
		push_cmd(ACT_LOAD, 8'hFF);
		push_cmd(ACT_LOAD, 8'h00);
		push_ticks(200);

		// random: mostly whole frames with stray loads, some noise
		frame_idx = 0;
		while (cmd_items.size() < ITEM_TARGET) begin
			if ($urandom_range(0, 4) != 0) begin
				case ($urandom_range(0, 9))
					0: fbyte = 8'h00;
					1: fbyte = 8'hFF;
					default: fbyte = BYTE_W'($urandom);
				endcase
				push_ticks($urandom_range(0, 20));
				push_cmd(ACT_LOAD, fbyte);
				n = $urandom_range(165, 215);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 39) == 0)
						push_cmd(ACT_LOAD, BYTE_W'($urandom));
					else
						push_cmd(ACT_TICK, BYTE_W'($urandom));
				end
				frame_idx++;
			end else begin
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++)
					push_cmd(action_t'($urandom_range(0, 1)), BYTE_W'($urandom));
			end
		end
		while (cmd_items.size() > ITEM_TARGET)
			void'(cmd_items.pop_back());

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_items.size() != 0 || cmd.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d results checked over %0d random frame sequences", res_cnt, frame_idx);
		$display("loads taken %0d, refused %0d, frames sent %0d, carrier pulses %0d",
			loads_taken, loads_refused, frames_sent, pin_pulses);
		if (err_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
